// File: rtl/bwcd_pkg.sv
`default_nettype none

package bwcd_pkg;

  localparam int LEVEL_W = 7;
  localparam int TIME_W  = 32;
  localparam int CODE_W  = 6;

  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 1'd1;

  localparam logic [LEVEL_W-1:0] LOW_THRESHOLD_RESET  = 7'd25;
  localparam logic [LEVEL_W-1:0] HIGH_THRESHOLD_RESET = 7'd65;

  localparam int PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_MARKER   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BAR      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_GAP      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COMPLETE = 3'd4;

  typedef struct packed {
    logic [LEVEL_W-1:0] low;
    logic [LEVEL_W-1:0] high;
  } thr_t;

endpackage

`default_nettype wire

// File: rtl/bar_width_code_decoder.sv
`default_nettype none

// Bar-width code decoder. Each item is one sensor sample with its millisecond
// timestamp; one item is taken per cycle unless in_stall is high. An accepted
// item lands in an input register and steps the phase machine as it leaves that
// register; the sample after the last bar emits the code to the output register.
// While a code waits under out_stall, the input register holds one more item
// and in_stall rises only after that. cfg_index 0 writes the low threshold, 1
// the high; the user must do so only while no item is in flight (not enforced).

module bar_width_code_decoder
  import bwcd_pkg::*;
#(
  parameter int BAR_COUNT     = 8,
  parameter int DURATION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [LEVEL_W-1:0]   in_sensor_level,
  input  wire logic [TIME_W-1:0]    in_now_ms,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [CODE_W-1:0]         out_code_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [LEVEL_W-1:0]   cfg_data
);

  logic               in_valid_r, in_valid_nxt;
  logic [LEVEL_W-1:0] in_level_r;
  logic [TIME_W-1:0]  in_now_r;
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_code_r;
  thr_t               thr_r;

  logic               advance;
  logic               load_in;
  logic               emit;
  logic [CODE_W-1:0]  code;

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign load_in   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_valid_nxt  = load_in || (in_valid_r && !advance);
  assign out_valid_nxt = (out_valid_r && out_stall) || (advance && emit);

  bwcd_core #(
    .BAR_COUNT     (BAR_COUNT),
    .DURATION_BITS (DURATION_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .level (in_level_r),
    .now   (in_now_r),
    .thr   (thr_r),
    .emit  (emit),
    .code  (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      in_level_r <= in_sensor_level;
      in_now_r   <= in_now_ms;
    end
    if (advance && emit) begin
      out_code_r <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.low  <= LOW_THRESHOLD_RESET;
      thr_r.high <= HIGH_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOW_THRESHOLD:  thr_r.low  <= cfg_data;
        CFG_HIGH_THRESHOLD: thr_r.high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_value = out_code_r;

endmodule

`default_nettype wire

// File: rtl/bwcd_core.sv
`default_nettype none

module bwcd_core
  import bwcd_pkg::*;
#(
  parameter int BAR_COUNT     = 8,
  parameter int DURATION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic [TIME_W-1:0]  now,
  input  wire thr_t               thr,
  output logic                    emit,
  output logic [CODE_W-1:0]       code
);

  localparam int CNT_W = $clog2(BAR_COUNT + 1);
  localparam int IDX_W = $clog2(BAR_COUNT);
  localparam logic [TIME_W:0] DUR_MAX = (33'd1 << DURATION_BITS) - 33'd1;
  localparam logic [CNT_W-1:0] BAR_LAST = CNT_W'(BAR_COUNT);

  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic [TIME_W-1:0]        seg_start_r, seg_start_nxt;
  logic [CNT_W-1:0]         bars_seen_r, bars_seen_nxt;
  logic [DURATION_BITS-1:0] short_r, short_nxt;
  logic [DURATION_BITS-1:0] long_r, long_nxt;
  logic [DURATION_BITS-1:0] dur_r [BAR_COUNT];

  logic                     dark, bright;
  logic [TIME_W-1:0]        diff;
  logic [DURATION_BITS-1:0] elapsed;
  logic [DURATION_BITS-1:0] mid;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_idx;

  assign dark   = level < thr.low;
  assign bright = level > thr.high;
  assign diff   = now - seg_start_r;
  assign wr_idx = bars_seen_r[IDX_W-1:0];

  always_comb begin
    if ({1'b0, diff} > DUR_MAX) begin
      elapsed = '1;
    end else begin
      elapsed = diff[DURATION_BITS-1:0];
    end
  end

  always_comb begin
    mid = short_r;
    if (long_r > short_r) begin
      mid = short_r + ((long_r - short_r) >> 1);
    end
  end

  always_comb begin
    code = '0;
    for (int k = 2; k < BAR_COUNT; k++) begin
      if (k - 2 < CODE_W) begin
        if (dur_r[k] > mid) begin
          code[k-2] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    seg_start_nxt = seg_start_r;
    bars_seen_nxt = bars_seen_r;
    short_nxt     = short_r;
    long_nxt      = long_r;
    wr_en         = 1'b0;
    emit          = 1'b0;
    case (phase_r)
      PH_MARKER: begin
        if (bright) begin
          short_nxt     = elapsed;
          long_nxt      = elapsed;
          seg_start_nxt = now;
          phase_nxt     = PH_BAR;
        end
      end
      PH_BAR: begin
        if (dark) begin
          if (elapsed < short_r) short_nxt = elapsed;
          if (elapsed > long_r) long_nxt = elapsed;
          wr_en         = bars_seen_r < BAR_LAST;
          bars_seen_nxt = bars_seen_r + 1'b1;
          phase_nxt     = (bars_seen_nxt >= BAR_LAST) ? PH_COMPLETE : PH_GAP;
        end
      end
      PH_GAP: begin
        if (bright) begin
          seg_start_nxt = now;
          phase_nxt     = PH_BAR;
        end
      end
      PH_COMPLETE: begin
        emit      = step;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (dark) begin
          seg_start_nxt = now;
          bars_seen_nxt = '0;
          phase_nxt     = PH_MARKER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      seg_start_r <= '0;
      bars_seen_r <= '0;
      short_r     <= '0;
      long_r      <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      seg_start_r <= seg_start_nxt;
      bars_seen_r <= bars_seen_nxt;
      short_r     <= short_nxt;
      long_r      <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      dur_r[wr_idx] <= elapsed;
    end
  end

`ifndef SYNTHESIS
  a_bars_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bars_seen_r <= BAR_LAST)
    else $error("bar count beyond bar total");

  a_complete_full: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COMPLETE |-> bars_seen_r == BAR_LAST)
    else $error("complete phase without all bars");

  a_complete_return: assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_COMPLETE |=> phase_r == PH_IDLE)
    else $error("no return to idle after emit");

  a_short_long: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BAR || phase_r == PH_GAP || phase_r == PH_COMPLETE)
      |-> short_r <= long_r)
    else $error("shortest duration above longest");
`endif

endmodule

`default_nettype wire

// File: dv/bar_width_code_decoder_tb.sv
`default_nettype none

module bar_width_code_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bwcd_pkg::*;

  localparam int NUM_BARS       = 8;
  localparam int BAR_IDX_W      = $clog2(NUM_BARS);
  localparam int DUR_W          = 16;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 940;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_sensor_level = '0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [CODE_W-1:0]    out_code_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LOW_THRESHOLD;
  logic [LEVEL_W-1:0]   cfg_data = '0;

  // decoder shadow state
  logic [LEVEL_W-1:0] thr_low = LOW_THRESHOLD_RESET;
  logic [LEVEL_W-1:0] thr_high = HIGH_THRESHOLD_RESET;
  logic [PHASE_W-1:0] ph = PH_IDLE;
  logic [TIME_W-1:0]  seg_start = '0;
  int unsigned        bars_done = 0;
  logic [DUR_W-1:0]   bar_len [NUM_BARS] = '{default: '0};
  logic [DUR_W-1:0]   min_len = '0;
  logic [DUR_W-1:0]   max_len = '0;
  logic [CODE_W-1:0]  code_q [$];

  logic [TIME_W-1:0]  stamp = '0;
  logic [CODE_W-1:0]  want;
  bit                 quiet = 1'b0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;
  int                 errors = 0;
  int                 samples_sent = 0;
  int                 codes_seen = 0;
  int                 cfg_writes = 0;

  bar_width_code_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sensor_level (in_sensor_level),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_value  (out_code_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DUR_W-1:0] elapsed_ms(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] diff;
    diff = now - seg_start;
    return (diff > 32'hFFFF) ? 16'hFFFF : diff[DUR_W-1:0];
  endfunction

  task automatic decode_sample(input logic [LEVEL_W-1:0] lvl, input logic [TIME_W-1:0] now);
    logic             dark;
    logic             bright;
    logic [DUR_W-1:0] d;
    logic [DUR_W-1:0] mid;
    logic [CODE_W-1:0] c;
    dark = lvl < thr_low;
    bright = lvl > thr_high;
    case (ph)
      PH_MARKER: begin
        if (bright) begin
          d = elapsed_ms(now);
          min_len = d;
          max_len = d;
          seg_start = now;
          ph = PH_BAR;
        end
      end
      PH_BAR: begin
        if (dark) begin
          d = elapsed_ms(now);
          if (d < min_len) min_len = d;
          if (d > max_len) max_len = d;
          if (bars_done < NUM_BARS) bar_len[BAR_IDX_W'(bars_done)] = d;
          bars_done++;
          ph = (bars_done >= NUM_BARS) ? PH_COMPLETE : PH_GAP;
        end
      end
      PH_GAP: begin
        if (bright) begin
          seg_start = now;
          ph = PH_BAR;
        end
      end
      PH_COMPLETE: begin
        mid = min_len;
        if (max_len > min_len) mid = mid + ((max_len - min_len) >> 1);
        c = '0;
        for (int k = 2; k < NUM_BARS; k++) begin
          if (bar_len[k] > mid) c[k-2] = 1'b1;
        end
        code_q.push_back(c);
        ph = PH_IDLE;
      end
      default: begin
        ph = PH_IDLE;
        if (dark) begin
          seg_start = now;
          bars_done = 0;
          ph = PH_MARKER;
        end
      end
    endcase
  endtask

  task automatic send_sample(input logic [LEVEL_W-1:0] lvl, input logic [TIME_W-1:0] now);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_level <= lvl;
    in_now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_sample(lvl, now);
    samples_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (code_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LOW_THRESHOLD) thr_low = val;
    else thr_high = val;
    cfg_writes++;
  endtask

  task automatic write_thresholds(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi);
    settle();
    write_reg(CFG_LOW_THRESHOLD, lo);
    write_reg(CFG_HIGH_THRESHOLD, hi);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LEVEL_W-1:0] dark_level();
    if ($urandom_range(0, 7) == 0) return '0;
    return LEVEL_W'($urandom_range(0, thr_low - 1));
  endfunction

  function automatic logic [LEVEL_W-1:0] bright_level();
    if ($urandom_range(0, 7) == 0) return 7'd127;
    return LEVEL_W'($urandom_range(thr_high + 1, 127));
  endfunction

  function automatic logic [LEVEL_W-1:0] calm_level(bit dark_side);
    if ($urandom_range(0, 1) == 0) return LEVEL_W'($urandom_range(thr_low, thr_high));
    return dark_side ? dark_level() : bright_level();
  endfunction

  task automatic send_random_level();
    logic [LEVEL_W-1:0] lvl;
    lvl = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 7'd127 : 7'd0)
                                      : LEVEL_W'($urandom_range(0, 127));
    case ($urandom_range(0, 19))
      0: stamp = $urandom();
      1: stamp = stamp + $urandom_range(65000, 140000);
      default: stamp = stamp + $urandom_range(0, 60);
    endcase
    send_sample(lvl, stamp);
  endtask

  // marker length first, then the eight bar lengths
  task automatic send_code(input logic [31:0] lens [9], input bit with_noise);
    send_sample(dark_level(), stamp);
    for (int i = 0; i < 9; i++) begin
      if (with_noise && $urandom_range(0, 3) == 0)
        send_sample(calm_level(i == 0), stamp + $urandom_range(0, lens[i]));
      stamp = stamp + lens[i];
      send_sample((i == 0) ? bright_level() : dark_level(), stamp);
      if (i != 0 && i < 8) begin
        stamp = stamp + $urandom_range(0, 50);
        if (with_noise && $urandom_range(0, 3) == 0) send_sample(calm_level(1'b1), stamp);
        send_sample(bright_level(), stamp);
      end
    end
    stamp = stamp + $urandom_range(0, 20);
    send_sample(LEVEL_W'($urandom_range(0, 127)), stamp);
    stamp = stamp + $urandom_range(0, 40);
  endtask

  task automatic pick_lengths(output logic [31:0] lens [9]);
    int unsigned narrow;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    narrow = $urandom_range(1, 300);
    for (int i = 0; i < 9; i++) begin
      if (mode < 6) begin
        lens[i] = $urandom_range(0, 1) ? narrow * $urandom_range(2, 4) : narrow;
      end else if (mode < 9) begin
        lens[i] = $urandom_range(0, 1000);
      end else begin
        case ($urandom_range(0, 3))
          0: lens[i] = 0;
          1: lens[i] = $urandom_range(65000, 140000);
          default: lens[i] = $urandom_range(0, 70000);
        endcase
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [CODE_W-1:0] exp_code,
                                 input logic [CODE_W-1:0] got_code);
    $display("%0t: %s: expected code %0d, got %0d", $realtime, what, exp_code, got_code);
    errors++;
  endtask

  // ignored samples, then one code across the timestamp wrap with saturated bars
  task automatic test_directed_edges();
    logic [31:0] lens [9];
    stamp = 32'hFFFF_FFF0;
    send_sample(7'd50, stamp);
    send_sample(7'd127, stamp);
    send_sample(7'd25, stamp);
    send_sample(7'd100, stamp);
    lens = '{32'h20, 10, 65535, 65536, 0, 100, 40000, 30, 200000};
    send_code(lens, 1'b0);
  endtask

  task automatic test_threshold_extremes();
    write_thresholds(7'd0, 7'd127);
    repeat (16) send_random_level();
    write_thresholds(7'd127, 7'd0);
    repeat (120) send_random_level();
    write_thresholds(7'd100, 7'd100);
    repeat (80) send_random_level();
    write_thresholds(7'd0, 7'd0);
    repeat (10) send_random_level();
    write_thresholds(7'd127, 7'd127);
    repeat (10) send_random_level();
  endtask

  task automatic test_random_codes();
    logic [31:0]        lens [9];
    logic [LEVEL_W-1:0] lo;
    int                 first;
    int                 round;
    int                 pick;
    first = samples_sent;
    round = 0;
    while (samples_sent - first < RANDOM_ITEMS) begin
      if (round % 12 == 0) begin
        quiet = 1'b0;
        case ($urandom_range(0, 3))
          0: write_thresholds(LOW_THRESHOLD_RESET, HIGH_THRESHOLD_RESET);
          1: write_thresholds(7'd1, 7'd126);
          default: begin
            lo = LEVEL_W'($urandom_range(1, 60));
            write_thresholds(lo, LEVEL_W'($urandom_range(lo, 126)));
          end
        endcase
      end
      round++;
      quiet = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        pick_lengths(lens);
        send_code(lens, $urandom_range(0, 1));
      end else if (pick == 8) begin
        send_sample(dark_level(), stamp);
        repeat ($urandom_range(2, 12)) send_random_level();
      end else begin
        repeat ($urandom_range(1, 6)) send_random_level();
      end
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (!quiet) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      codes_seen++;
      if (code_q.size() == 0) begin
        report_mismatch("code with none pending", '0, out_code_value);
      end else begin
        want = code_q.pop_front();
        if (want != out_code_value) report_mismatch("code_value mismatch", want, out_code_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d codes pending",
                 idle_cycles, code_q.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_threshold_extremes();
    test_random_codes();
    settle();
    $display("%0d samples, %0d codes checked, %0d threshold writes, %0d mismatches",
             samples_sent, codes_seen, cfg_writes, errors);
    $display("covered: ignored levels, wrap and saturation, threshold extremes, noisy codes");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
